### hw/rtl/aes_block_cipher_defines.svh
// assertion helpers for the cipher rtl
`ifndef AES_BLOCK_CIPHER_DEFINES_SVH
`define AES_BLOCK_CIPHER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define AES_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aes same-cycle check failed");

// next-cycle implication, checked out of reset
`define AES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aes next-cycle check failed");

`endif

### hw/rtl/aes_pkg.sv
package aes_pkg;

    typedef logic [7:0] byte_tab_t [256];

    // round kinds
    localparam logic [1:0] KIND_FIRST = 2'd0;
    localparam logic [1:0] KIND_MID   = 2'd1;
    localparam logic [1:0] KIND_LAST  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_KEY_LENGTH = 3'd0;
    localparam logic [2:0] CFG_KEY_WORD3  = 3'd4;

    localparam int RK_DEPTH = 15;
    localparam int RK_WIDTH = 128;

    typedef struct packed {
        logic       load;
        logic       exp_start;
        logic       exp_step;
        logic       round_en;
        logic [1:0] kind;
        logic [3:0] raddr;
        logic       out_load;
    } aes_cmd_t;

    typedef struct packed {
        logic       exp_last;
        logic       dec;
        logic [3:0] nr;
        logic       out_busy;
        logic       cfg_hit;
    } aes_status_t;

    localparam byte_tab_t SBOX = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic byte_tab_t build_inv_sbox();
        byte_tab_t t;
        for (int x = 0; x < 256; x++) begin
            t[SBOX[x]] = x[7:0];
        end
        return t;
    endfunction

    localparam byte_tab_t INV_SBOX = build_inv_sbox();

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // state byte k sits at [127-8k -: 8]
    function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        for (int k = 0; k < 16; k++) begin
            t[127-8*k -: 8] = inv ? INV_SBOX[s[127-8*k -: 8]] : SBOX[s[127-8*k -: 8]];
        end
        return t;
    endfunction

    function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                if (inv) begin
                    t[127-8*(r+4*((c+r)%4)) -: 8] = s[127-8*(r+4*c) -: 8];
                end else begin
                    t[127-8*(r+4*c) -: 8] = s[127-8*(r+4*((c+r)%4)) -: 8];
                end
            end
        end
        return t;
    endfunction

    function automatic logic [31:0] mix_col(input logic [31:0] col, input logic inv);
        logic [7:0] b [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] m2 [4];
        logic [7:0] m3 [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        logic [31:0] o;
        for (int k = 0; k < 4; k++) begin
            b[k]  = col[31-8*k -: 8];
            x2[k] = xtime(b[k]);
            x4[k] = xtime(x2[k]);
            x8[k] = xtime(x4[k]);
            m2[k] = x2[k];
            m3[k] = x2[k] ^ b[k];
            m9[k] = x8[k] ^ b[k];
            mb[k] = x8[k] ^ x2[k] ^ b[k];
            md[k] = x8[k] ^ x4[k] ^ b[k];
            me[k] = x8[k] ^ x4[k] ^ x2[k];
        end
        for (int r = 0; r < 4; r++) begin
            if (inv) begin
                o[31-8*r -: 8] = me[r] ^ mb[(r+1)%4] ^ md[(r+2)%4] ^ m9[(r+3)%4];
            end else begin
                o[31-8*r -: 8] = m2[r] ^ m3[(r+1)%4] ^ b[(r+2)%4] ^ b[(r+3)%4];
            end
        end
        return o;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        for (int c = 0; c < 4; c++) begin
            t[127-32*c -: 32] = mix_col(s[127-32*c -: 32], inv);
        end
        return t;
    endfunction

endpackage

### hw/rtl/aes_ram.sv
module aes_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 15
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/aes_dp.sv
module aes_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    input  logic                in_cmd,
    input  logic [127:0]        in_block,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [127:0]        m_tdata,
    input  aes_pkg::aes_cmd_t   cmd,
    output aes_pkg::aes_status_t status
);

    logic [1:0]   key_len_reg;
    logic [63:0]  key_word_reg [4];
    logic [1:0]   kl;
    logic [3:0]   nk;
    logic [3:0]   nr;
    logic [2:0]   nk_m1;
    logic         cfg_hit;

    logic [31:0]  win_reg [8];
    logic [5:0]   idx_reg;
    logic [2:0]   mod_reg;
    logic [7:0]   rcon_reg;
    logic [5:0]   total_m1;
    logic [63:0]  kw;
    logic [31:0]  t_word;
    logic [31:0]  new_word;
    logic         in_key;

    logic [127:0] state_reg;
    logic [127:0] state_next;
    logic         dec_reg;
    logic [127:0] rk;
    logic [127:0] e_sr;
    logic [127:0] e_mc;
    logic [127:0] d_t;
    logic         out_valid_reg;
    logic [127:0] out_data_reg;

    assign cfg_hit = cfg_valid && (cfg_index <= aes_pkg::CFG_KEY_WORD3);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_len_reg <= '0;
            for (int i = 0; i < 4; i++) begin
                key_word_reg[i] <= '0;
            end
        end else if (cfg_hit) begin
            if (cfg_index == aes_pkg::CFG_KEY_LENGTH) begin
                key_len_reg <= cfg_data[1:0];
            end else begin
                key_word_reg[2'(cfg_index - 3'd1)] <= cfg_data;
            end
        end
    end

    // code 3 runs as a 256-bit key
    assign kl       = (key_len_reg == 2'd3) ? 2'd2 : key_len_reg;
    assign nk       = 4'd4 + {1'b0, kl, 1'b0};
    assign nr       = nk + 4'd6;
    assign nk_m1    = nk[2:0] - 3'd1;
    assign total_m1 = {nr, 2'b00} + 6'd3;

    // key schedule, one word per cycle
    assign in_key = (idx_reg < {2'b00, nk});
    assign kw     = key_word_reg[idx_reg[2:1]];

    always_comb begin
        t_word = win_reg[0];
        if (mod_reg == 3'd0) begin
            t_word = aes_pkg::sub_word({win_reg[0][23:0], win_reg[0][31:24]})
                     ^ {rcon_reg, 24'h0};
        end else if (nk == 4'd8 && mod_reg == 3'd4) begin
            t_word = aes_pkg::sub_word(win_reg[0]);
        end
        if (in_key) begin
            new_word = idx_reg[0] ? kw[31:0] : kw[63:32];
        end else begin
            new_word = win_reg[nk_m1] ^ t_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exp_start) begin
            idx_reg  <= '0;
            mod_reg  <= '0;
            rcon_reg <= 8'h01;
        end else if (cmd.exp_step) begin
            for (int i = 7; i > 0; i--) begin
                win_reg[i] <= win_reg[i-1];
            end
            win_reg[0] <= new_word;
            idx_reg    <= idx_reg + 6'd1;
            mod_reg    <= (mod_reg == nk_m1) ? 3'd0 : mod_reg + 3'd1;
            if (!in_key && mod_reg == 3'd0) begin
                rcon_reg <= aes_pkg::xtime(rcon_reg);
            end
        end
    end

    aes_ram #(
        .WIDTH(aes_pkg::RK_WIDTH),
        .DEPTH(aes_pkg::RK_DEPTH)
    ) u_rk_ram (
        .aclk (aclk),
        .we   (cmd.exp_step && idx_reg[1:0] == 2'd3),
        .waddr(idx_reg[5:2]),
        .wdata({win_reg[2], win_reg[1], win_reg[0], new_word}),
        .raddr(cmd.raddr),
        .rdata(rk)
    );

    // shared round unit
    assign e_sr = aes_pkg::shift_rows(aes_pkg::sub_bytes(state_reg, 1'b0), 1'b0);
    assign e_mc = aes_pkg::mix_columns(e_sr, 1'b0);
    assign d_t  = aes_pkg::sub_bytes(aes_pkg::shift_rows(state_reg, 1'b1), 1'b1) ^ rk;

    always_comb begin
        case (cmd.kind)
            aes_pkg::KIND_FIRST: state_next = state_reg ^ rk;
            aes_pkg::KIND_MID:   state_next = dec_reg ? aes_pkg::mix_columns(d_t, 1'b1)
                                                      : e_mc ^ rk;
            aes_pkg::KIND_LAST:  state_next = dec_reg ? d_t : e_sr ^ rk;
            default:             state_next = state_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
            dec_reg   <= 1'b0;
        end else if (cmd.load) begin
            state_reg <= in_block;
            dec_reg   <= in_cmd;
        end else if (cmd.round_en) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            out_data_reg <= state_reg;
        end
    end

    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = {out_data_reg[63:0], out_data_reg[127:64]};
    assign status.exp_last = (idx_reg == total_m1);
    assign status.dec      = dec_reg;
    assign status.nr       = nr;
    assign status.out_busy = out_valid_reg && !m_tready;
    assign status.cfg_hit  = cfg_hit;

endmodule

### hw/rtl/aes_ctrl.sv
`include "aes_block_cipher_defines.svh"

module aes_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  aes_pkg::aes_status_t status,
    output aes_pkg::aes_cmd_t   cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXPAND = 3'd1;
    localparam logic [2:0] ST_READ   = 3'd2;
    localparam logic [2:0] ST_ROUND  = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [3:0] rc_reg;
    logic [3:0] rc_next;
    logic       expanded_reg;
    logic       expanded_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next    = state_reg;
        rc_next       = rc_reg;
        expanded_next = expanded_reg;
        cmd           = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.load = 1'b1;
                    if (expanded_reg) begin
                        state_next = ST_READ;
                    end else begin
                        cmd.exp_start = 1'b1;
                        state_next    = ST_EXPAND;
                    end
                end
            end
            ST_EXPAND: begin
                cmd.exp_step = 1'b1;
                if (status.exp_last) begin
                    expanded_next = 1'b1;
                    state_next    = ST_READ;
                end
            end
            ST_READ: begin
                cmd.raddr  = status.dec ? status.nr : 4'd0;
                rc_next    = 4'd0;
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.round_en = 1'b1;
                rc_next      = rc_reg + 4'd1;
                if (rc_reg == 4'd0) begin
                    cmd.kind = aes_pkg::KIND_FIRST;
                end else if (rc_reg == status.nr) begin
                    cmd.kind   = aes_pkg::KIND_LAST;
                    state_next = ST_DONE;
                end else begin
                    cmd.kind = aes_pkg::KIND_MID;
                end
                // no key read after the last round
                if (rc_reg != status.nr) begin
                    cmd.raddr = status.dec ? status.nr - rc_reg - 4'd1 : rc_reg + 4'd1;
                end
            end
            ST_DONE: begin
                if (!status.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (status.cfg_hit) begin
            expanded_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rc_reg       <= '0;
            expanded_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rc_reg       <= rc_next;
            expanded_reg <= expanded_next;
        end
    end

    `AES_ASSERT_NEXT(a_accept_leaves_idle, aclk, aresetn, accept, state_reg != ST_IDLE)
    `AES_ASSERT_NEXT(a_last_round_done, aclk, aresetn, cmd.round_en && cmd.kind == aes_pkg::KIND_LAST, state_reg == ST_DONE)
    `AES_ASSERT_NOW(a_out_load_free, aclk, aresetn, cmd.out_load, !status.out_busy)
    `AES_ASSERT_NEXT(a_cfg_clears_keys, aclk, aresetn, status.cfg_hit, !expanded_reg)
    `AES_ASSERT_NOW(a_round_with_keys, aclk, aresetn, state_reg == ST_ROUND, expanded_reg)

endmodule

### hw/rtl/aes_block_cipher.sv
// block path: accept, round-key read, nr + 1 rounds (nr = 10, 12 or 14), one round per cycle,
// then result hand-off once the output register is free; new blocks are taken only in idle
// the first block after reset or any key write first expands 4 * (nr + 1) round-key words
// reset: aresetn synchronous active low; key registers return to zero, keys marked unexpanded
// the round-key store is not cleared, it is always filled before use
module aes_block_cipher (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data,
    // input block words
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // block_high [63:0], block_low [127:64]
    input  logic         s_tuser,   // cmd: 0 encrypt, 1 decrypt
    // result words
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata    // result_high [63:0], result_low [127:64]
);

    aes_pkg::aes_cmd_t    cmd;
    aes_pkg::aes_status_t status;

    // writes must only land while idle, a rule on the user that the block does not enforce; the port never stalls
    assign cfg_ready = 1'b1;

    // sequencer: key expansion, round stepping, result hand-off
    aes_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .status  (status),
        .cmd     (cmd)
    );

    // datapath: key registers, key schedule, round-key ram, round unit, output register
    aes_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_cmd   (s_tuser),
        .in_block ({s_tdata[63:0], s_tdata[127:64]}),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

### dv/testbench.sv
module testbench;

    localparam int CLK_HALF    = 6;
    localparam int RANDOM_WORDS = 850;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    localparam logic [2:0] REG_KEY_LENGTH = aes_pkg::CFG_KEY_LENGTH;
    localparam logic [2:0] REG_KEY_WORD0  = 3'd1;
    localparam logic [2:0] REG_KEY_WORD1  = 3'd2;
    localparam logic [2:0] REG_KEY_WORD2  = 3'd3;
    localparam logic [2:0] REG_KEY_WORD3  = aes_pkg::CFG_KEY_WORD3;
    localparam logic [2:0] REG_UNUSED     = 3'd5;

    localparam logic [1:0] KEYLEN_128 = 2'd0;
    localparam logic [1:0] KEYLEN_192 = 2'd1;
    localparam logic [1:0] KEYLEN_256 = 2'd2;
    localparam logic [1:0] KEYLEN_RSVD = 2'd3;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [63:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;

    aes_block_cipher dut (.*);

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // predictor copy of the key registers and the expanded schedule
    logic [1:0]  key_len_reg;
    logic [63:0] key_reg [4];
    logic [31:0] sched [60];

    typedef struct {
        logic [63:0] high;
        logic [63:0] low;
        logic        checked;   // expectation typed in by hand
    } cipher_out_t;

    cipher_out_t pending_blocks [$];
    int  mismatch_count = 0;
    int  cycle_count = 0;
    bit  hold_off = 1'b0;
    int  last_nr = 14;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    function automatic int key_nk();
        return (key_len_reg >= KEYLEN_256) ? 8 : 4 + 2 * key_len_reg;
    endfunction

    function automatic logic [7:0] gf_double(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = '0;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p ^= a;
            a = gf_double(a);
        end
        return p;
    endfunction

    function automatic logic [31:0] sbox_word(input logic [31:0] w);
        return {aes_pkg::SBOX[w[31:24]], aes_pkg::SBOX[w[23:16]],
                aes_pkg::SBOX[w[15:8]], aes_pkg::SBOX[w[7:0]]};
    endfunction

    function automatic void build_schedule();
        int nk;
        logic [31:0] t;
        logic [7:0]  rc;
        nk = key_nk();
        rc = 8'h01;
        for (int i = 0; i < nk; i++) begin
            sched[i] = i[0] ? key_reg[i/2][31:0] : key_reg[i/2][63:32];
        end
        for (int i = nk; i < 4 * (nk + 7); i++) begin
            t = sched[i-1];
            if (i % nk == 0) begin
                t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
                rc = gf_double(rc);
            end else if (nk > 6 && i % nk == 4) begin
                t = sbox_word(t);
            end
            sched[i] = sched[i-nk] ^ t;
        end
    endfunction

    // state bytes kept in column order, byte k = row k%4 of column k/4
    typedef logic [7:0] state_t [16];

    function automatic void add_key(ref state_t s, input int r);
        for (int c = 0; c < 4; c++)
            for (int row = 0; row < 4; row++)
                s[row + 4*c] ^= sched[4*r + c][31 - 8*row -: 8];
    endfunction

    function automatic void round_ops(ref state_t s, input bit inv, input bit mix);
        state_t t;
        logic [7:0] col [4];
        logic [7:0] fwd [4] = '{8'd2, 8'd3, 8'd1, 8'd1};
        logic [7:0] rev [4] = '{8'd14, 8'd11, 8'd13, 8'd9};
        for (int k = 0; k < 16; k++) s[k] = inv ? aes_pkg::INV_SBOX[s[k]] : aes_pkg::SBOX[s[k]];
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                if (inv) t[r + 4*((c+r)%4)] = s[r + 4*c];
                else     t[r + 4*c] = s[r + 4*((c+r)%4)];
        s = t;
        if (!mix) return;
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) col[k] = s[4*c + k];
            for (int r = 0; r < 4; r++) begin
                s[4*c + r] = 0;
                for (int k = 0; k < 4; k++)
                    s[4*c + r] ^= gf_mul(inv ? rev[(k-r)&3] : fwd[(k-r)&3], col[k]);
            end
        end
    endfunction

    function automatic void round_ops_mix_only(ref state_t s);
        logic [7:0] col [4];
        logic [7:0] rev [4] = '{8'd14, 8'd11, 8'd13, 8'd9};
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) col[k] = s[4*c + k];
            for (int r = 0; r < 4; r++) begin
                s[4*c + r] = 0;
                for (int k = 0; k < 4; k++) s[4*c + r] ^= gf_mul(rev[(k-r)&3], col[k]);
            end
        end
    endfunction

    function automatic logic [127:0] cipher_block(input logic cmd, input logic [63:0] hi,
                                                  input logic [63:0] lo);
        state_t s;
        int nr;
        nr = key_nk() + 6;
        for (int i = 0; i < 8; i++) begin
            s[i] = hi[63 - 8*i -: 8];
            s[8+i] = lo[63 - 8*i -: 8];
        end
        if (cmd == CMD_ENCRYPT) begin
            add_key(s, 0);
            for (int r = 1; r < nr; r++) begin
                round_ops(s, 1'b0, 1'b1);
                add_key(s, r);
            end
            round_ops(s, 1'b0, 1'b0);
            add_key(s, nr);
        end else begin
            // inverse cipher: mix after the key add, so do sub/shift then key then mix
            add_key(s, nr);
            for (int r = nr - 1; r >= 1; r--) begin
                round_ops(s, 1'b1, 1'b0);
                add_key(s, r);
                round_ops_mix_only(s);
            end
            round_ops(s, 1'b1, 1'b0);
            add_key(s, 0);
        end
        for (int i = 0; i < 8; i++) begin
            hi[63 - 8*i -: 8] = s[i];
            lo[63 - 8*i -: 8] = s[8+i];
        end
        return {lo, hi};
    endfunction

    // register write, only while idle; keeps the predictor copy in step
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_KEY_LENGTH) key_len_reg = value[1:0];
        else if (idx <= REG_KEY_WORD3) key_reg[2'(idx - 3'd1)] = value;
        if (idx <= REG_KEY_WORD3) build_schedule();
        @(posedge aclk);
    endtask

    task automatic set_key(input logic [1:0] len, input logic [63:0] k0, input logic [63:0] k1,
                           input logic [63:0] k2, input logic [63:0] k3);
        write_reg(REG_KEY_LENGTH, {62'h0, len});
        write_reg(REG_KEY_WORD0, k0);
        write_reg(REG_KEY_WORD1, k1);
        write_reg(REG_KEY_WORD2, k2);
        write_reg(REG_KEY_WORD3, k3);
    endtask

    // one input word; queues its expected result once the word is taken
    task automatic send_block(input logic cmd, input logic [63:0] hi, input logic [63:0] lo,
                              input bit typed, input logic [63:0] exp_hi,
                              input logic [63:0] exp_lo);
        cipher_out_t e;
        logic [127:0] r;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {lo, hi};
        do @(posedge aclk); while (!s_tready);
        r = cipher_block(cmd, hi, lo);
        e.high = r[63:0];
        e.low = r[127:64];
        e.checked = typed;
        if (typed && (e.high !== exp_hi || e.low !== exp_lo))
            $display("note: predictor disagrees with typed vector");
        if (typed) begin
            e.high = exp_hi;
            e.low = exp_lo;
        end
        pending_blocks = {pending_blocks, e};
    endtask

    task automatic sender_gap();
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge aclk);
    endtask

    task automatic drain();
        while (pending_blocks.size() != 0) @(posedge aclk);
        // worst case a block still in flight
        repeat (4 * 15 + 20) @(posedge aclk);
    endtask

    // result checker
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_blocks.size() == 0) begin
                report_mismatch("unexpected word", m_tdata[63:0], '0);
            end else begin
                cipher_out_t e;
                e = pending_blocks.pop_front();
                if (m_tdata[63:0] !== e.high)
                    report_mismatch(e.checked ? "typed result_high" : "result_high",
                                    m_tdata[63:0], e.high);
                if (m_tdata[127:64] !== e.low)
                    report_mismatch(e.checked ? "typed result_low" : "result_low",
                                    m_tdata[127:64], e.low);
            end
        end
    end

    // receiver: its own stall pattern, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_off) m_tready <= 1'b0;
        else case (cycle_count[9:8])
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= ($urandom_range(0, 3) != 0);
            2'd2: m_tready <= ($urandom_range(0, 1) != 0);
            default: m_tready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    typedef struct {
        logic        cmd;
        logic [63:0] hi;
        logic [63:0] lo;
        bit          typed;
        logic [63:0] exp_hi;
        logic [63:0] exp_lo;
    } vec_t;

    vec_t fips_128 [7] = '{
        '{CMD_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff, 1,
          64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a},
        '{CMD_DECRYPT, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1,
          64'h0011223344556677, 64'h8899aabbccddeeff},
        '{CMD_ENCRYPT, 64'h0, 64'h0, 0, 0, 0},
        '{CMD_ENCRYPT, '1, '1, 0, 0, 0},
        '{CMD_DECRYPT, 64'h0, 64'h0, 0, 0, 0},
        '{CMD_DECRYPT, '1, '1, 0, 0, 0},
        '{CMD_ENCRYPT, 64'h8000000000000000, 64'h1, 0, 0, 0}
    };

    initial begin
        logic [63:0] k [4];
        logic [1:0]  len;
        key_len_reg = KEYLEN_128;
        for (int i = 0; i < 4; i++) key_reg[i] = '0;
        build_schedule();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // all-zero key straight after reset
        send_block(CMD_ENCRYPT, 64'h0, 64'h0, 1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e);
        send_block(CMD_DECRYPT, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e, 1, 64'h0, 64'h0);
        sender_gap();
        drain();

        set_key(KEYLEN_128, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h0, 64'h0);
        foreach (fips_128[i]) begin
            send_block(fips_128[i].cmd, fips_128[i].hi, fips_128[i].lo, fips_128[i].typed,
                       fips_128[i].exp_hi, fips_128[i].exp_lo);
        end
        s_tvalid <= 1'b0;
        drain();

        set_key(KEYLEN_192, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                64'h1011121314151617, 64'h0);
        send_block(CMD_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff, 1,
                   64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191);
        send_block(CMD_DECRYPT, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191, 1,
                   64'h0011223344556677, 64'h8899aabbccddeeff);
        s_tvalid <= 1'b0;
        drain();

        set_key(KEYLEN_256, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                64'h1011121314151617, 64'h18191a1b1c1d1e1f);
        send_block(CMD_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff, 1,
                   64'h8ea2b7ca516745bf, 64'heafc49904b496089);
        send_block(CMD_DECRYPT, 64'h8ea2b7ca516745bf, 64'heafc49904b496089, 1,
                   64'h0011223344556677, 64'h8899aabbccddeeff);
        s_tvalid <= 1'b0;
        drain();

        // reserved length code acts as a 256-bit key; ignored index changes nothing
        write_reg(REG_KEY_LENGTH, {62'h0, KEYLEN_RSVD});
        write_reg(REG_UNUSED, '1);
        send_block(CMD_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff, 1,
                   64'h8ea2b7ca516745bf, 64'heafc49904b496089);
        s_tvalid <= 1'b0;
        drain();

        // all-ones key, every length
        for (int l = 0; l < 3; l++) begin
            set_key(l[1:0], '1, '1, '1, '1);
            send_block(CMD_ENCRYPT, '1, '1, 0, 0, 0);
            send_block(CMD_DECRYPT, '1, '1, 0, 0, 0);
            s_tvalid <= 1'b0;
            drain();
        end

        // random phases, each with a fresh key; one phase with a long receiver hold-off
        for (int phase = 0; phase < 17; phase++) begin
            len = (phase < 3) ? phase[1:0] : 2'($urandom_range(0, 3));
            for (int i = 0; i < 4; i++) k[i] = {$urandom, $urandom};
            set_key(len, k[0], k[1], k[2], k[3]);
            if (phase == 5) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (400) @(posedge aclk);
                        hold_off = 1'b0;
                    end
                join_none
            end
            for (int n = 0; n < RANDOM_WORDS / 17; n++) begin
                send_block(1'($urandom_range(0, 1)), {$urandom, $urandom},
                           {$urandom, $urandom}, 0, 0, 0);
                if ($urandom_range(0, 9) < 3) sender_gap();
            end
            s_tvalid <= 1'b0;
            drain();
        end

        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
